// ===== src/vort_pkg.sv =====
`default_nettype none

package vort_pkg;

  // Configuration register indexes, in the order of the register list.
  localparam int CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRAME_COLUMNS = 2'd0,
    CFG_FRAME_ROWS    = 2'd1,
    CFG_INV_SPACING   = 2'd2
  } cfg_idx_e;

  // Register widths and reset values.
  localparam int ColRegW   = 11;
  localparam int RowW      = 12;
  localparam int FactorW   = 24;
  localparam int CfgDataW  = 24;
  localparam int CenterColW = 10;

  localparam logic [ColRegW-1:0] ColsReset   = 11'd1024;
  localparam logic [RowW-1:0]    RowsReset   = 12'd1024;
  localparam logic [FactorW-1:0] FactorReset = 24'd32768;

  // Smallest stencil size along either axis.
  localparam int MinSize = 3;

  // The factor is Q8.16, so the product drops 16 fraction bits with rounding.
  localparam int FracShift = 16;

  // Result is signed Q24.0 in 24 bits: whole units of the scaled difference.
  localparam int ResultW = 24;
  localparam logic [ResultW-1:0] ResultMaxPos = 24'h7FFFFF;
  localparam logic [ResultW-1:0] ResultMinNeg = 24'h800000;

endpackage

`default_nettype wire

// ===== src/vorticity_central_difference_2d.sv =====
`default_nettype none

// Streaming 2D vorticity (z-curl) by central differences.
// Input channel: one beat per grid point in raster order carrying velocity_x,
// velocity_y and frame_start; frame_start places the beat at row 0, column 0.
// Position also wraps to the origin after the last point of a frame.
// Output channel: one beat per interior point with its row, column and the
// saturated curl; border points produce no beat.
// Config channel: index 0 frame columns, 1 frame rows, 2 inverse double
// spacing (Q8.16); always ready, write only while the block is idle.
// Throughput: one input beat per cycle while the output is not stalled. A result
// passes through the input register, the difference stage, the multiply stage
// and the output register; the single line-store read port per store and the
// one multiplier set the one-beat-per-cycle rate.
// Reset clears the position counters, the pipeline valids and the sample
// window. The line stores are not cleared: the first two rows of a frame fill
// them before any interior point reads them.
// When the receiver stalls, the output beat holds and the stages behind it
// fill; input ready drops only once every stage is occupied.
module vorticity_central_difference_2d #(
  parameter int MAX_COLUMNS = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Configuration write port
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [vort_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  wire logic [vort_pkg::CfgDataW-1:0]      cfg_data_i,
  // Sample input
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic signed [SAMPLE_BITS-1:0]      velocity_x_i,
  input  wire logic signed [SAMPLE_BITS-1:0]      velocity_y_i,
  input  wire logic                               frame_start_i,
  // Result output
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic [vort_pkg::RowW-1:0]               center_row_o,
  output logic [vort_pkg::CenterColW-1:0]         center_column_o,
  output logic signed [vort_pkg::ResultW-1:0]     vorticity_o
);
  import vort_pkg::*;

  localparam int ColW  = $clog2(MAX_COLUMNS);
  localparam int CntW  = ColW + 1;
  localparam int CmpW  = (CntW > ColRegW) ? CntW : ColRegW;
  localparam int DiffW = SAMPLE_BITS + 2;
  localparam int ProdW = DiffW + FactorW;
  localparam int QuoW  = ProdW + 1 - FracShift;
  localparam int SatW  = (QuoW > ResultW + 1) ? QuoW : ResultW + 1;
  localparam int XDepth = 2 ** CntW;

  localparam logic [DiffW-1:0] MagLimit  = {1'b1, {(DiffW-1){1'b0}}};
  localparam logic [ProdW:0]   RoundHalf = (ProdW + 1)'(1) << (FracShift - 1);
  localparam logic [SatW-1:0]  SatPos    = SatW'(ResultMaxPos);
  localparam logic [SatW-1:0]  SatNeg    = {{(SatW-ResultW){1'b0}}, ResultMinNeg};

  // Configuration registers
  logic [ColRegW-1:0] frame_columns_q;
  logic [RowW-1:0]    frame_rows_q;
  logic [FactorW-1:0] inv_spacing_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_columns_q <= ColsReset;
      frame_rows_q    <= RowsReset;
      inv_spacing_q   <= FactorReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_FRAME_COLUMNS: frame_columns_q <= cfg_data_i[ColRegW-1:0];
        CFG_FRAME_ROWS:    frame_rows_q    <= cfg_data_i[RowW-1:0];
        CFG_INV_SPACING:   inv_spacing_q   <= cfg_data_i[FactorW-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame size, clamped to what the stencil and the stores allow.
  logic [CmpW-1:0] cols_ext;
  logic [CntW-1:0] eff_cols;
  logic [RowW-1:0] eff_rows;

  assign cols_ext = CmpW'(frame_columns_q);
  assign eff_cols = (cols_ext < CmpW'(MinSize))     ? CntW'(MinSize) :
                    (cols_ext > CmpW'(MAX_COLUMNS)) ? CntW'(MAX_COLUMNS) :
                                                       CntW'(cols_ext);
  assign eff_rows = (frame_rows_q < RowW'(MinSize)) ? RowW'(MinSize) : frame_rows_q;

  // Pipeline handshake: each stage moves when the one ahead is empty or moving.
  logic s1_valid_q, s1_emit_q;
  logic s2_valid_q, s3_valid_q, out_valid_q;
  logic out_stage_ready, s3_ready, s2_ready, s1_fire, in_fire;

  assign out_stage_ready = !out_valid_q || out_ready_i;
  assign s3_ready        = !s3_valid_q || out_stage_ready;
  assign s2_ready        = !s2_valid_q || s3_ready;
  assign s1_fire         = s1_valid_q && (!s1_emit_q || s2_ready);
  assign in_ready_o      = !s1_valid_q || s1_fire;
  assign in_fire         = in_valid_i && in_ready_o;

  // Raster position of the incoming beat and of the one after it.
  logic [ColW-1:0] col_q;
  logic [RowW-1:0] row_q;
  logic [CntW-1:0] col_start, col_wrap, col_next;
  logic [RowW-1:0] row_start, row_wrap, row_cur, row_next;
  logic [ColW-1:0] col_cur, col_left;
  logic            pre_wrap, end_of_row, emit;

  assign col_start  = frame_start_i ? '0 : CntW'(col_q);
  assign row_start  = frame_start_i ? '0 : row_q;
  assign pre_wrap   = col_start >= eff_cols;
  assign col_wrap   = pre_wrap ? '0 : col_start;
  assign row_wrap   = pre_wrap ? row_start + RowW'(1) : row_start;
  assign row_cur    = (row_wrap >= eff_rows) ? '0 : row_wrap;
  assign col_cur    = col_wrap[ColW-1:0];
  assign col_left   = col_cur - ColW'(1);
  assign col_next   = CntW'(col_cur) + CntW'(1);
  assign end_of_row = col_next >= eff_cols;
  assign row_next   = row_cur + RowW'(1);
  assign emit       = (row_cur >= RowW'(2)) && (col_cur >= ColW'(2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_fire) begin
      if (end_of_row) begin
        col_q <= '0;
        row_q <= (row_next >= eff_rows) ? '0 : row_next;
      end else begin
        col_q <= col_next[ColW-1:0];
        row_q <= row_cur;
      end
    end
  end

  // Previous x sample, kept in step with the input beats.
  logic signed [SAMPLE_BITS-1:0] prev_x_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q <= '0;
    end else if (in_fire) begin
      prev_x_q <= velocity_x_i;
    end
  end

  // Line stores: two x rows banked by row parity, one y row. Read before write.
  logic signed [SAMPLE_BITS-1:0] x_mem [XDepth];
  logic signed [SAMPLE_BITS-1:0] y_mem [MAX_COLUMNS];
  logic signed [SAMPLE_BITS-1:0] x_rd_q, y_rd_q;
  logic [CntW-1:0]               x_addr;

  assign x_addr = {row_cur[0], col_left};

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      if (col_cur != '0) begin
        x_mem[x_addr] <= prev_x_q;
      end
      x_rd_q        <= x_mem[x_addr];
      y_mem[col_cur] <= velocity_y_i;
      y_rd_q        <= y_mem[col_cur];
    end
  end

  // Stage 1: input register beside the store read data.
  logic [RowW-1:0]               s1_row_q;
  logic [ColW-1:0]               s1_col_q;
  logic signed [SAMPLE_BITS-1:0] s1_px_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_emit_q  <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
      s1_emit_q  <= emit;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_row_q <= row_cur - RowW'(1);
      s1_col_q <= col_left;
      s1_px_q  <= prev_x_q;
    end
  end

  // Window of the two previous y values from the row above.
  logic signed [SAMPLE_BITS-1:0] win0_q, win1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win0_q <= '0;
      win1_q <= '0;
    end else if (s1_fire) begin
      win1_q <= win0_q;
      win0_q <= y_rd_q;
    end
  end

  // Difference sum and its magnitude.
  logic signed [DiffW-1:0] diff, diff_neg;
  logic [DiffW-1:0]        diff_mag;

  assign diff = (DiffW'(y_rd_q) - DiffW'(win1_q)) - (DiffW'(s1_px_q) - DiffW'(x_rd_q));
  assign diff_neg = -diff;
  assign diff_mag = diff[DiffW-1] ? diff_neg : diff;

  // Stage 2: sign and magnitude.
  logic [RowW-1:0]  s2_row_q;
  logic [ColW-1:0]  s2_col_q;
  logic             s2_neg_q;
  logic [DiffW-1:0] s2_mag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_fire && s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_fire && s1_emit_q) begin
      s2_row_q <= s1_row_q;
      s2_col_q <= s1_col_q;
      s2_neg_q <= diff[DiffW-1];
      s2_mag_q <= diff_mag;
    end
  end

  // Stage 3: scale by the inverse double spacing.
  logic [RowW-1:0]  s3_row_q;
  logic [ColW-1:0]  s3_col_q;
  logic             s3_neg_q;
  logic [ProdW-1:0] s3_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (s3_ready) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_ready && s2_valid_q) begin
      s3_row_q  <= s2_row_q;
      s3_col_q  <= s2_col_q;
      s3_neg_q  <= s2_neg_q;
      s3_prod_q <= ProdW'(s2_mag_q) * ProdW'(inv_spacing_q);
    end
  end

  // Round half away from zero on the magnitude, then saturate.
  logic [ProdW:0]       round_sum;
  logic [SatW-1:0]      quo;
  logic [ResultW-1:0]   result;

  assign round_sum = {1'b0, s3_prod_q} + RoundHalf;
  assign quo       = SatW'(round_sum[ProdW:FracShift]);

  always_comb begin
    if (s3_neg_q) begin
      result = (quo > SatNeg) ? ResultMinNeg : ResultW'(0) - quo[ResultW-1:0];
    end else begin
      result = (quo > SatPos) ? ResultMaxPos : quo[ResultW-1:0];
    end
  end

  // Output register.
  logic [RowW-1:0]    out_row_q;
  logic [ColW-1:0]    out_col_q;
  logic [ResultW-1:0] out_vort_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_stage_ready) begin
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_stage_ready && s3_valid_q) begin
      out_row_q  <= s3_row_q;
      out_col_q  <= s3_col_q;
      out_vort_q <= result;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign center_row_o    = out_row_q;
  assign center_column_o = CenterColW'(out_col_q);
  assign vorticity_o     = out_vort_q;

  // A frame start always lands on the top border, which yields no result.
  a_frame_start_no_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && frame_start_i |=> s1_valid_q && !s1_emit_q)
    else $error("frame start beat marked as interior point");

  // Interior points never sit on row 0 or column 0.
  a_emit_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_emit_q |-> (s1_row_q != '0) && (s1_col_q != '0))
    else $error("interior point with border coordinates");

  // The magnitude of the difference sum stays within its signed range.
  a_mag_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> s2_mag_q <= MagLimit)
    else $error("difference magnitude out of range");

  // A scaled result that moves forward reaches the output register.
  a_result_reaches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q && out_stage_ready |=> out_valid_o)
    else $error("result lost between multiply stage and output");

endmodule

`default_nettype wire

// ===== bench/vorticity_central_difference_2d_tb.sv =====
`timescale 1ns / 100ps

module vorticity_central_difference_2d_tb;
  import vort_pkg::*;

  localparam int MaxColumns   = 1024;
  localparam int SampleBits   = 16;
  localparam int SettleCycles = 8;
  localparam int DrainLimit   = 4000;
  localparam int RegimeBeats  = 250;
  localparam int WideBeats    = 250;

  // One expected curl result.
  typedef struct packed {
    logic [RowW-1:0]       row;
    logic [CenterColW-1:0] col;
    logic [ResultW-1:0]    vort;
  } curl_t;

  typedef enum logic {STEP_BEAT, STEP_WRITE} step_e;
  typedef enum logic [1:0] {EXP_PREDICTED, EXP_TYPED, EXP_SILENT} exp_mode_e;

  typedef struct packed {
    step_e                 op;
    cfg_idx_e              reg_idx;
    logic [CfgDataW-1:0]   reg_data;
    logic [SampleBits-1:0] vx;
    logic [SampleBits-1:0] vy;
    logic                  start;
    exp_mode_e             mode;
    logic [RowW-1:0]       exp_row;
    logic [CenterColW-1:0] exp_col;
    logic [ResultW-1:0]    exp_vort;
  } script_row_t;

  // Directed opening: a few beats at the reset sizes, then a mid-row shrink to
  // three columns and three rows, then frames aimed at both saturation limits
  // and a rounding tie. Each 3x3 frame yields one interior point at (1,1).
  localparam int DirSteps = 32;
  localparam script_row_t DirectedScript [DirSteps] = '{
    '{STEP_BEAT,  CFG_FRAME_COLUMNS, 24'h0, 16'h0000, 16'h0000, 1'b1, EXP_SILENT, 12'd0, 10'd0, 24'h0},
    '{STEP_BEAT,  CFG_FRAME_COLUMNS, 24'h0, 16'h7FFF, 16'h0000, 1'b0, EXP_SILENT, 12'd0, 10'd0, 24'h0},
    '{STEP_BEAT,  CFG_FRAME_COLUMNS, 24'h0, 16'hFFFF, 16'hFFFF, 1'b0, EXP_SILENT, 12'd0, 10'd0, 24'h0},
    '{STEP_BEAT,  CFG_FRAME_COLUMNS, 24'h0, 16'h0000, 16'h0000, 1'b0, EXP_SILENT, 12'd0, 10'd0, 24'h0},
    '{STEP_WRITE, CFG_FRAME_COLUMNS, 24'd2, 16'h0000, 16'h0000, 1'b0, EXP_SILENT, 12'd0, 10'd0, 24'h0},
    '{STEP_WRITE, CFG_FRAME_ROWS,    24'd0, 16'h0000, 16'h0000, 1'b0, EXP_SILENT, 12'd0, 10'd0, 24'h0},
    '{STEP_WRITE, CFG_INV_SPACING, 24'hFFFFFF, 16'h0, 16'h0000, 1'b0, EXP_SILENT, 12'd0, 10'd0, 24'h0},
    '{STEP_BEAT,  CFG_FRAME_COLUMNS, 24'h0, 16'h0000, 16'h8000, 1'b0, EXP_SILENT, 12'd0, 10'd0, 24'h0},
    '{STEP_BEAT,  CFG_FRAME_COLUMNS, 24'h0, 16'h0000, 16'h0000, 1'b0, EXP_SILENT, 12'd0, 10'd0, 24'h0},
    '{STEP_BEAT,  CFG_FRAME_COLUMNS, 24'h0, 16'h0000, 16'h7FFF, 1'b0, EXP_SILENT, 12'd0, 10'd0, 24'h0},
    '{STEP_BEAT,  CFG_FRAME_COLUMNS, 24'h0, 16'h0000, 16'h0000, 1'b0, EXP_SILENT, 12'd0, 10'd0, 24'h0},
    '{STEP_BEAT,  CFG_FRAME_COLUMNS, 24'h0, 16'h8000, 16'h0000, 1'b0, EXP_SILENT, 12'd0, 10'd0, 24'h0},
    '{STEP_BEAT,  CFG_FRAME_COLUMNS, 24'h0, 16'h0000, 16'h0000, 1'b0, EXP_TYPED, 12'd1, 10'd1,
      24'h7FFFFF},
    // This frame starts by wrapping at the end of the previous one.
    '{STEP_BEAT,  CFG_FRAME_COLUMNS, 24'h0, 16'h0000, 16'h0000, 1'b0, EXP_SILENT, 12'd0, 10'd0, 24'h0},
    '{STEP_BEAT,  CFG_FRAME_COLUMNS, 24'h0, 16'h8000, 16'h0000, 1'b0, EXP_SILENT, 12'd0, 10'd0, 24'h0},
    '{STEP_BEAT,  CFG_FRAME_COLUMNS, 24'h0, 16'h0000, 16'h0000, 1'b0, EXP_SILENT, 12'd0, 10'd0, 24'h0},
    '{STEP_BEAT,  CFG_FRAME_COLUMNS, 24'h0, 16'h0000, 16'h7FFF, 1'b0, EXP_SILENT, 12'd0, 10'd0, 24'h0},
    '{STEP_BEAT,  CFG_FRAME_COLUMNS, 24'h0, 16'h0000, 16'h0000, 1'b0, EXP_SILENT, 12'd0, 10'd0, 24'h0},
    '{STEP_BEAT,  CFG_FRAME_COLUMNS, 24'h0, 16'h0000, 16'h8000, 1'b0, EXP_SILENT, 12'd0, 10'd0, 24'h0},
    '{STEP_BEAT,  CFG_FRAME_COLUMNS, 24'h0, 16'h0000, 16'h0000, 1'b0, EXP_SILENT, 12'd0, 10'd0, 24'h0},
    '{STEP_BEAT,  CFG_FRAME_COLUMNS, 24'h0, 16'h7FFF, 16'h0000, 1'b0, EXP_SILENT, 12'd0, 10'd0, 24'h0},
    '{STEP_BEAT,  CFG_FRAME_COLUMNS, 24'h0, 16'h0000, 16'h0000, 1'b0, EXP_TYPED, 12'd1, 10'd1,
      24'h800000},
    '{STEP_WRITE, CFG_INV_SPACING, 24'd32768, 16'h0, 16'h0000, 1'b0, EXP_SILENT, 12'd0, 10'd0, 24'h0},
    // Difference of minus one at one half: the tie rounds away from zero.
    '{STEP_BEAT,  CFG_FRAME_COLUMNS, 24'h0, 16'h0000, 16'h0000, 1'b1, EXP_SILENT, 12'd0, 10'd0, 24'h0},
    '{STEP_BEAT,  CFG_FRAME_COLUMNS, 24'h0, 16'h0000, 16'h0000, 1'b0, EXP_SILENT, 12'd0, 10'd0, 24'h0},
    '{STEP_BEAT,  CFG_FRAME_COLUMNS, 24'h0, 16'h0000, 16'h0000, 1'b0, EXP_SILENT, 12'd0, 10'd0, 24'h0},
    '{STEP_BEAT,  CFG_FRAME_COLUMNS, 24'h0, 16'h0000, 16'h0000, 1'b0, EXP_SILENT, 12'd0, 10'd0, 24'h0},
    '{STEP_BEAT,  CFG_FRAME_COLUMNS, 24'h0, 16'h0000, 16'h0000, 1'b0, EXP_SILENT, 12'd0, 10'd0, 24'h0},
    '{STEP_BEAT,  CFG_FRAME_COLUMNS, 24'h0, 16'h0000, 16'h0000, 1'b0, EXP_SILENT, 12'd0, 10'd0, 24'h0},
    '{STEP_BEAT,  CFG_FRAME_COLUMNS, 24'h0, 16'h0000, 16'h0000, 1'b0, EXP_SILENT, 12'd0, 10'd0, 24'h0},
    '{STEP_BEAT,  CFG_FRAME_COLUMNS, 24'h0, 16'h0001, 16'h0000, 1'b0, EXP_SILENT, 12'd0, 10'd0, 24'h0},
    '{STEP_BEAT,  CFG_FRAME_COLUMNS, 24'h0, 16'h0000, 16'h0000, 1'b0, EXP_TYPED, 12'd1, 10'd1,
      24'hFFFFFF}
  };

  // Clock, reset and block inputs, all known from time zero.
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                         cfg_valid_i   = 1'b0;
  logic                         cfg_ready_o;
  cfg_idx_e                     cfg_index_i   = CFG_FRAME_COLUMNS;
  logic [CfgDataW-1:0]          cfg_data_i    = '0;
  logic                         in_valid_i    = 1'b0;
  logic                         in_ready_o;
  logic signed [SampleBits-1:0] velocity_x_i  = '0;
  logic signed [SampleBits-1:0] velocity_y_i  = '0;
  logic                         frame_start_i = 1'b0;
  logic                         out_valid_o;
  logic                         out_ready_i   = 1'b0;
  logic [RowW-1:0]              center_row_o;
  logic [CenterColW-1:0]        center_column_o;
  logic signed [ResultW-1:0]    vorticity_o;

  // Idle rates in percent for the two channels.
  int sender_gap_pct     = 0;
  int receiver_stall_pct = 0;

  // Run bookkeeping.
  curl_t pending_curls [$];
  int    failures       = 0;
  int    beats_sent     = 0;
  int    curls_checked  = 0;
  int    settings_count = 0;

  // Predictor state: line stores, sample window, raster position, registers.
  logic signed [SampleBits-1:0] x_lines [2*MaxColumns];
  logic signed [SampleBits-1:0] y_line  [MaxColumns];
  logic signed [SampleBits-1:0] prev_x;
  logic signed [SampleBits-1:0] y_window [2];
  int unsigned                  col_pos;
  int unsigned                  row_pos;
  logic [ColRegW-1:0]           col_setting;
  logic [RowW-1:0]              row_setting;
  logic [FactorW-1:0]           factor_setting;

  vorticity_central_difference_2d #(
    .MAX_COLUMNS(MaxColumns),
    .SAMPLE_BITS(SampleBits)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .velocity_x_i   (velocity_x_i),
    .velocity_y_i   (velocity_y_i),
    .frame_start_i  (frame_start_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .center_row_o   (center_row_o),
    .center_column_o(center_column_o),
    .vorticity_o    (vorticity_o)
  );

  always #1 clk_i = ~clk_i;

  // Scale the stencil difference by the Q8.16 factor, round half away from
  // zero and clamp to the 24-bit result range.
  function automatic logic [ResultW-1:0] scale_curl(input int signed diff);
    longint unsigned mag;
    longint unsigned q;
    mag = (diff < 0) ? longint'(-diff) : longint'(diff);
    q = (mag * longint'(factor_setting) + (64'd1 << (FracShift - 1))) >> FracShift;
    if (diff < 0) begin
      return (q > 64'(ResultMaxPos) + 64'd1) ? ResultMinNeg : ResultW'(64'd0 - q);
    end
    return (q > 64'(ResultMaxPos)) ? ResultMaxPos : ResultW'(q);
  endfunction

  // Advance the raster position by one beat and work out the curl of the
  // interior point that this beat completes, if any.
  task automatic predict_curl(input logic signed [SampleBits-1:0] vx, vy, input logic start,
                              output bit produced, output curl_t res);
    int unsigned cols;
    int unsigned rows;
    int unsigned c;
    int unsigned r;
    int unsigned bank;
    logic signed [SampleBits-1:0] above_y;
    logic signed [SampleBits-1:0] two_up_x;
    int signed diff;
    cols = (col_setting < MinSize) ? MinSize :
           (col_setting > MaxColumns) ? MaxColumns : col_setting;
    rows = (row_setting < MinSize) ? MinSize : row_setting;
    produced = 1'b0;
    res = '0;
    if (start) begin
      col_pos = 0;
      row_pos = 0;
    end
    // A position left beyond shrunk sizes moves on before it is used.
    if (col_pos >= cols) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= rows) row_pos = 0;
    c = col_pos;
    r = row_pos;
    bank = (r % 2) * MaxColumns;
    above_y = y_line[c];
    if (c >= 1) begin
      two_up_x = x_lines[bank + c - 1];
      if (r >= 2 && c >= 2) begin
        diff = (int'(above_y) - int'(y_window[1])) - (int'(prev_x) - int'(two_up_x));
        res.row  = RowW'(r - 1);
        res.col  = CenterColW'(c - 1);
        res.vort = scale_curl(diff);
        produced = 1'b1;
      end
      x_lines[bank + c - 1] = prev_x;
    end
    y_line[c] = vy;
    y_window[1] = y_window[0];
    y_window[0] = above_y;
    prev_x = vx;
    col_pos = c + 1;
    if (col_pos >= cols) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= rows) row_pos = 0;
    end
  endtask

  function automatic logic signed [SampleBits-1:0] pick_sample();
    case ($urandom_range(15))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      3: return 16'shFFFF;
      default: return SampleBits'($urandom());
    endcase
  endfunction

  // Send one sample beat. Valid stays high after acceptance so that the next
  // beat can follow back to back; a gap lowers it first.
  task automatic send_beat(input logic signed [SampleBits-1:0] vx, vy, input logic start,
                           input exp_mode_e mode, input curl_t typed);
    bit    produced;
    curl_t predicted;
    cfg_valid_i <= 1'b0;
    while ($urandom_range(99) < sender_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    velocity_x_i  <= vx;
    velocity_y_i  <= vy;
    frame_start_i <= start;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_curl(vx, vy, start, produced, predicted);
    beats_sent++;
    case (mode)
      EXP_PREDICTED: if (produced) pending_curls.push_back(predicted);
      EXP_TYPED:     pending_curls.push_back(typed);
      default: ;
    endcase
  endtask

  // Stop sending and wait until every expected result has come out, then let
  // the pipeline run empty of beats that produce nothing.
  task automatic settle_pipeline();
    int waited;
    in_valid_i  <= 1'b0;
    cfg_valid_i <= 1'b0;
    waited = 0;
    while (pending_curls.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_curls.size() != 0) begin
      $error("%0d expected curl results never arrived", pending_curls.size());
      failures++;
      pending_curls.delete();
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apply_setting(input cfg_idx_e idx, input logic [CfgDataW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_FRAME_COLUMNS: col_setting    = value[ColRegW-1:0];
      CFG_FRAME_ROWS:    row_setting    = value[RowW-1:0];
      CFG_INV_SPACING:   factor_setting = value[FactorW-1:0];
      default: ;
    endcase
  endtask

  // One setting of all three registers followed by a stream of beats. The
  // first beat marks a frame start so that wider rows are filled before use.
  task automatic run_phase(input int unsigned cols, rows, input logic [FactorW-1:0] factor,
                           input int unsigned beats);
    settle_pipeline();
    apply_setting(CFG_FRAME_COLUMNS, CfgDataW'(cols));
    apply_setting(CFG_FRAME_ROWS, CfgDataW'(rows));
    apply_setting(CFG_INV_SPACING, factor);
    settings_count++;
    for (int n = 0; n < beats; n++) begin
      if (n != 0 && $urandom_range(199) == 0) settle_pipeline();
      send_beat(pick_sample(), pick_sample(), n == 0 || $urandom_range(59) == 0,
                EXP_PREDICTED, '0);
    end
  endtask

  // Mostly small frames, with clamped sizes and extreme factors mixed in.
  task automatic random_phase();
    int unsigned cols;
    int unsigned rows;
    int unsigned eff_cols;
    int unsigned eff_rows;
    logic [FactorW-1:0] factor;
    case ($urandom_range(7))
      0:       cols = $urandom_range(0, 2);
      1:       cols = $urandom_range(10, 20);
      default: cols = $urandom_range(3, 9);
    endcase
    rows = ($urandom_range(7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
    case ($urandom_range(7))
      0:       factor = '0;
      1:       factor = '1;
      2:       factor = FactorReset;
      3:       factor = FactorW'($urandom_range(0, 255));
      default: factor = FactorW'($urandom());
    endcase
    eff_cols = (cols < MinSize) ? MinSize : cols;
    eff_rows = (rows < MinSize) ? MinSize : rows;
    run_phase(cols, rows, factor,
              eff_cols * eff_rows * $urandom_range(1, 3) + $urandom_range(0, 2 * eff_cols));
  endtask

  // Receiver side: random stalls at the current rate.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Compare each result beat with the oldest expectation.
  always @(posedge clk_i) begin
    curl_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_curls.size() == 0) begin
        $error("unexpected curl result: row %0d column %0d value %0d",
               center_row_o, center_column_o, vorticity_o);
        failures++;
      end else begin
        want = pending_curls.pop_front();
        curls_checked++;
        if (center_row_o !== want.row) begin
          $error("center_row: expected %0d, got %0d", want.row, center_row_o);
          failures++;
        end
        if (center_column_o !== want.col) begin
          $error("center_column: expected %0d, got %0d", want.col, center_column_o);
          failures++;
        end
        if (vorticity_o !== want.vort) begin
          $error("vorticity: expected %0d, got %0d", $signed(want.vort), vorticity_o);
          failures++;
        end
      end
    end
  end

  // Main sequence.
  initial begin
    curl_t typed;
    for (int i = 0; i < 2 * MaxColumns; i++) x_lines[i] = '0;
    for (int i = 0; i < MaxColumns; i++) y_line[i] = '0;
    prev_x         = '0;
    y_window[0]    = '0;
    y_window[1]    = '0;
    col_pos        = 0;
    row_pos        = 0;
    col_setting    = ColsReset;
    row_setting    = RowsReset;
    factor_setting = FactorReset;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed script under the first idle regime.
    sender_gap_pct     = 31;
    receiver_stall_pct = 87;
    for (int i = 0; i < DirSteps; i++) begin
      if (DirectedScript[i].op == STEP_WRITE) begin
        if (i == 0 || DirectedScript[i-1].op != STEP_WRITE) begin
          settle_pipeline();
          settings_count++;
        end
        apply_setting(DirectedScript[i].reg_idx, DirectedScript[i].reg_data);
      end else begin
        typed.row  = DirectedScript[i].exp_row;
        typed.col  = DirectedScript[i].exp_col;
        typed.vort = DirectedScript[i].exp_vort;
        send_beat(DirectedScript[i].vx, DirectedScript[i].vy, DirectedScript[i].start,
                  DirectedScript[i].mode, typed);
      end
    end

    // Random part in three idle regimes; each opens with an extreme setting.
    for (int regime = 0; regime < 3; regime++) begin
      int start_beats;
      case (regime)
        0: begin
          sender_gap_pct     = 31;
          receiver_stall_pct = 87;
          run_phase(2, 2, '1, 60);
        end
        1: begin
          sender_gap_pct     = 87;
          receiver_stall_pct = 31;
          run_phase(3, 4095, FactorW'($urandom()), 90);
        end
        default: begin
          sender_gap_pct     = 0;
          receiver_stall_pct = 0;
          // Widest setting, clamped to the store size: part of the first row.
          run_phase(2047, 3, FactorW'($urandom()), WideBeats);
        end
      endcase
      start_beats = beats_sent;
      while (beats_sent - start_beats < RegimeBeats) random_phase();
    end

    settle_pipeline();
    $display("run covered %0d sample beats, %0d curl results, %0d register settings",
             beats_sent, curls_checked, settings_count);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Safety net against a hung handshake.
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/vort_pkg.sv
src/vorticity_central_difference_2d.sv
bench/vorticity_central_difference_2d_tb.sv
